FILE: src/rssi_pkg.sv
// Shared constants, types and command/status structs of the ramp/soak setpoint interpolator.
package rssi_pkg;

   // Profile geometry and number formats.
   localparam int MaxStages  = 4;
   localparam int StageSlots = 4;
   localparam int StageIdxW  = 2;
   localparam int CountW     = 3;
   localparam int TempW      = 13;
   localparam int DurW       = 16;
   localparam int WordW      = 29;
   localparam int TimeW      = 18;
   localparam int ProdW      = DurW + TempW;
   localparam int CsrIndexW  = 3;
   localparam int ReqDataW   = 24;
   localparam int RspDataW   = 16;

   // Ambient start temperature, 25 C in 1/16 C units.
   localparam logic [TempW-1:0] Ambient = 13'd400;

   // Division runs one quotient bit per cycle.
   localparam logic [4:0] DivLast = 5'(ProdW - 1);

   // Configuration register indexes.
   localparam logic [CsrIndexW-1:0] RegStageCount = 3'd0;
   localparam logic [CsrIndexW-1:0] RegStage0     = 3'd1;
   localparam logic [CsrIndexW-1:0] RegStage1     = 3'd2;
   localparam logic [CsrIndexW-1:0] RegStage2     = 3'd3;
   localparam logic [CsrIndexW-1:0] RegStage3     = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic walk;
      logic mul;
      logic div;
      logic fix;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic walk_direct;
      logic walk_interp;
      logic out_free;
   } status_type;

endpackage

FILE: src/ramp_soak_setpoint_interpolator.sv
// Top level of the ramp/soak setpoint interpolator: controller plus datapath.
//
//   Channel   Direction  Payload
//   req_      in         tdata[17:0] elapsed_seconds
//   rsp_      out        tdata[12:0] setpoint
//   csr_      in         write: csr_index 0 stage_count, 1..4 stage words
//
// An item whose result is a stage target or ambient is accepted, walks the stages and
// then loads the output register. An interpolated item is accepted, walks the stages,
// then passes through the multiply, the bit-serial restoring divide and the final add
// or subtract before the output register is loaded.
// Reset is synchronous and clears the controller, the output valid and the configuration registers.
// A finished result waits in the output register while the next item is taken in.
module ramp_soak_setpoint_interpolator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [rssi_pkg::ReqDataW-1:0]         req_tdata,   // [17:0] elapsed_seconds
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [rssi_pkg::RspDataW-1:0]         rsp_tdata,   // [12:0] setpoint
   input  logic                                  csr_we,
   input  logic [rssi_pkg::CsrIndexW-1:0]        csr_index,
   input  logic [rssi_pkg::WordW-1:0]            csr_data
);

   rssi_pkg::cmd_type             cmd;
   rssi_pkg::status_type          status;
   logic [rssi_pkg::TempW-1:0]    setpoint;

   rssi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rssi_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .elapsed_seconds (req_tdata[rssi_pkg::TimeW-1:0]),
      .cmd             (cmd),
      .status          (status),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .setpoint        (setpoint)
   );

   // Pad the setpoint to whole bytes.
   assign rsp_tdata = {{(rssi_pkg::RspDataW - rssi_pkg::TempW){1'b0}}, setpoint};

endmodule

FILE: src/rssi_ctrl.sv
// Controller state machine that sequences the stage walk, multiply and serial divide.
module rssi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  rssi_pkg::status_type status,
   output rssi_pkg::cmd_type    cmd
);

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StWalk = 3'd1;
   localparam logic [2:0] StMul  = 3'd2;
   localparam logic [2:0] StDiv  = 3'd3;
   localparam logic [2:0] StFix  = 3'd4;
   localparam logic [2:0] StDone = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [4:0] count_ff, count_in;

   assign req_tready = (state_ff == StIdle);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd      = '0;
      case (state_ff)
         StIdle: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = StWalk;
            end
         end
         StWalk: begin
            cmd.walk = 1'b1;
            if (status.walk_direct) begin
               state_in = StDone;
            end else if (status.walk_interp) begin
               state_in = StMul;
            end
         end
         StMul: begin
            cmd.mul  = 1'b1;
            count_in = '0;
            state_in = StDiv;
         end
         StDiv: begin
            cmd.div = 1'b1;
            if (count_ff == rssi_pkg::DivLast) begin
               state_in = StFix;
            end else begin
               count_in = count_ff + 5'd1;
            end
         end
         StFix: begin
            cmd.fix  = 1'b1;
            state_in = StDone;
         end
         StDone: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: src/rssi_dp.sv
// Datapath: profile registers, stage walk, multiplier, restoring divider and result register.
module rssi_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rssi_pkg::CsrIndexW-1:0]      csr_index,
   input  logic [rssi_pkg::WordW-1:0]          csr_data,
   input  logic [rssi_pkg::TimeW-1:0]          elapsed_seconds,
   input  rssi_pkg::cmd_type                   cmd,
   output rssi_pkg::status_type                status,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rssi_pkg::TempW-1:0]          setpoint
);

   // Configuration registers.
   logic [rssi_pkg::CountW-1:0] stage_count_ff;
   logic [rssi_pkg::WordW-1:0]  stage_word_ff [rssi_pkg::StageSlots];

   // Walk and arithmetic registers.
   logic [rssi_pkg::TimeW-1:0]     elapsed_ff;
   logic [rssi_pkg::TimeW-1:0]     start_ff;
   logic [rssi_pkg::TempW-1:0]     prev_ff;
   logic [rssi_pkg::StageIdxW-1:0] idx_ff;
   logic [rssi_pkg::DurW-1:0]      diff_ff;
   logic [rssi_pkg::TempW-1:0]     delta_ff;
   logic                           down_ff;
   logic [rssi_pkg::DurW-1:0]      dur_ff;
   logic [rssi_pkg::ProdW-1:0]     num_ff;
   logic [rssi_pkg::DurW-1:0]      rem_ff;
   logic [rssi_pkg::TempW-1:0]     res_ff;
   logic                           out_valid_ff;
   logic [rssi_pkg::TempW-1:0]     out_data_ff;

   logic [rssi_pkg::CountW-1:0] n_eff;
   logic                        no_stages;
   logic [rssi_pkg::DurW-1:0]   cur_dur;
   logic [rssi_pkg::TempW-1:0]  cur_tgt;
   logic [rssi_pkg::TimeW:0]    cur_end;
   logic                        hit;
   logic                        last;
   logic [rssi_pkg::TimeW-1:0]  offset;
   logic [rssi_pkg::ProdW-1:0]  product;
   logic [rssi_pkg::DurW:0]     trial;
   logic                        fits;
   logic [rssi_pkg::DurW:0]     trial_sub;

   // Stage count saturates at the profile size.
   assign n_eff = (stage_count_ff > rssi_pkg::CountW'(rssi_pkg::MaxStages))
                  ? rssi_pkg::CountW'(rssi_pkg::MaxStages) : stage_count_ff;
   assign no_stages = (n_eff == '0);

   // Current stage decode and end-time compare.
   assign cur_dur = stage_word_ff[idx_ff][rssi_pkg::DurW-1:0];
   assign cur_tgt = stage_word_ff[idx_ff][rssi_pkg::WordW-1:rssi_pkg::DurW];
   assign cur_end = {1'b0, start_ff} + (rssi_pkg::TimeW+1)'(cur_dur);
   assign hit     = ({1'b0, elapsed_ff} <= cur_end);
   assign last    = (({1'b0, idx_ff} + rssi_pkg::CountW'(1)) == n_eff);
   assign offset  = elapsed_ff - start_ff;

   assign status.walk_direct = no_stages || (hit && (cur_dur == '0)) || (!hit && last);
   assign status.walk_interp = !no_stages && hit && (cur_dur != '0);
   assign status.out_free    = !out_valid_ff || rsp_tready;

   // Multiplier and one restoring divide step.
   assign product   = {{rssi_pkg::TempW{1'b0}}, diff_ff} * {{rssi_pkg::DurW{1'b0}}, delta_ff};
   assign trial     = {rem_ff, num_ff[rssi_pkg::ProdW-1]};
   assign fits      = (trial >= {1'b0, dur_ff});
   assign trial_sub = trial - {1'b0, dur_ff};

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_count_ff <= '0;
         for (int i = 0; i < rssi_pkg::StageSlots; i++) begin
            stage_word_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            rssi_pkg::RegStageCount: stage_count_ff   <= csr_data[rssi_pkg::CountW-1:0];
            rssi_pkg::RegStage0:     stage_word_ff[0] <= csr_data;
            rssi_pkg::RegStage1:     stage_word_ff[1] <= csr_data;
            rssi_pkg::RegStage2:     stage_word_ff[2] <= csr_data;
            rssi_pkg::RegStage3:     stage_word_ff[3] <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Stage walk, multiply, divide and final add or subtract.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         elapsed_ff <= elapsed_seconds;
         start_ff   <= '0;
         prev_ff    <= rssi_pkg::Ambient;
         idx_ff     <= '0;
      end
      if (cmd.walk) begin
         if (no_stages) begin
            res_ff <= rssi_pkg::Ambient;
         end else if (hit) begin
            res_ff  <= cur_tgt;
            diff_ff <= offset[rssi_pkg::DurW-1:0];
            dur_ff  <= cur_dur;
            down_ff <= (cur_tgt < prev_ff);
            delta_ff <= (cur_tgt < prev_ff) ? (prev_ff - cur_tgt) : (cur_tgt - prev_ff);
         end else begin
            // Move on to the next stage; the last target holds past the end.
            prev_ff  <= cur_tgt;
            start_ff <= cur_end[rssi_pkg::TimeW-1:0];
            idx_ff   <= idx_ff + rssi_pkg::StageIdxW'(1);
            res_ff   <= cur_tgt;
         end
      end
      if (cmd.mul) begin
         num_ff <= product;
         rem_ff <= '0;
      end
      if (cmd.div) begin
         rem_ff <= fits ? trial_sub[rssi_pkg::DurW-1:0] : trial[rssi_pkg::DurW-1:0];
         num_ff <= {num_ff[rssi_pkg::ProdW-2:0], fits};
      end
      if (cmd.fix) begin
         res_ff <= down_ff ? (prev_ff - num_ff[rssi_pkg::TempW-1:0])
                           : (prev_ff + num_ff[rssi_pkg::TempW-1:0]);
      end
   end

   // Output register lets the next item start while a result waits.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_data_ff <= res_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign setpoint   = out_data_ff;

endmodule

FILE: tb/tb_ramp_soak_setpoint_interpolator.sv
// Self-checking testbench for the ramp/soak setpoint interpolator: stream driver, monitor, checker.
module tb_ramp_soak_setpoint_interpolator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MaxElapsed    = (1 << rssi_pkg::TimeW) - 1;
   localparam int WatchdogLimit = 5000;
   localparam int LongHold      = 400;
   localparam int SettleCycles  = 64;
   localparam int RandPhases    = 12;
   localparam int PhaseItems    = 38;
   localparam int PressurePhase = 2;

   // Block ports; the inputs are at known values from time zero.
   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [rssi_pkg::ReqDataW-1:0]  req_tdata  = '0;   // [17:0] elapsed_seconds
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [rssi_pkg::RspDataW-1:0]  rsp_tdata;         // [12:0] setpoint
   logic                           csr_we     = 1'b0;
   logic [rssi_pkg::CsrIndexW-1:0] csr_index  = '0;
   logic [rssi_pkg::WordW-1:0]     csr_data   = '0;

   // Profile registers as the block should hold them.
   logic [rssi_pkg::CountW-1:0]    cfg_count = '0;
   logic [rssi_pkg::WordW-1:0]     cfg_word [rssi_pkg::StageSlots];

   // Elapsed times waiting to be sent, and setpoints waiting to come back.
   logic [rssi_pkg::TimeW-1:0]     pending_elapsed [$];
   logic [rssi_pkg::TempW-1:0]     expected_setpoints [$];
   logic [rssi_pkg::TempW-1:0]     want_setpoint;

   int                   gap_left     = 0;
   int                   stall_left   = 0;
   int                   hold_token   = 0;
   int                   hold_seen    = 0;
   int                   idle_cycles  = 0;
   int                   mismatches   = 0;
   bit                   idle_on      = 1'b0;

   ramp_soak_setpoint_interpolator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Setpoint for an elapsed time under the current profile.
   function automatic logic [rssi_pkg::TempW-1:0] setpoint_for(
      input logic [rssi_pkg::TimeW-1:0] elapsed);
      int unsigned                n;
      int unsigned                start;
      int unsigned                stop;
      int unsigned                dur;
      logic [rssi_pkg::TempW-1:0] prev;
      logic [rssi_pkg::TempW-1:0] tgt;
      longint unsigned            span;
      longint unsigned            diff;
      longint unsigned            delta;
      n = (cfg_count > rssi_pkg::MaxStages) ? rssi_pkg::MaxStages : cfg_count;
      if (n == 0) return rssi_pkg::Ambient;
      prev  = rssi_pkg::Ambient;
      start = 0;
      for (int i = 0; i < n; i++) begin
         tgt  = cfg_word[i][rssi_pkg::WordW-1:rssi_pkg::DurW];
         dur  = cfg_word[i][rssi_pkg::DurW-1:0];
         stop = start + dur;
         if (elapsed <= stop) begin
            // A stage of zero length jumps straight to its target.
            if (dur == 0) return tgt;
            span = elapsed - start;
            if (tgt >= prev) begin
               diff  = tgt - prev;
               delta = span * diff / dur;
               return prev + rssi_pkg::TempW'(delta);
            end
            diff  = prev - tgt;
            delta = span * diff / dur;
            return prev - rssi_pkg::TempW'(delta);
         end
         prev  = tgt;
         start = stop;
      end
      // Past the end of the profile the last target holds.
      return prev;
   endfunction

   // Random elapsed time, mostly inside the profile and around stage ends.
   function automatic logic [rssi_pkg::TimeW-1:0] pick_elapsed();
      int n;
      int total;
      int value;
      int stop_at [rssi_pkg::MaxStages];
      n     = (cfg_count > rssi_pkg::MaxStages) ? rssi_pkg::MaxStages : cfg_count;
      total = 0;
      for (int i = 0; i < n; i++) begin
         total      = total + cfg_word[i][rssi_pkg::DurW-1:0];
         stop_at[i] = total;
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: value = $urandom_range(0, total);
         5, 6: begin
            if (n == 0) value = $urandom_range(0, MaxElapsed);
            else value = stop_at[$urandom_range(0, n - 1)] + $urandom_range(0, 2) - 1;
         end
         7: value = $urandom_range(0, MaxElapsed);
         8: value = total + $urandom_range(0, 1000);
         default: value = $urandom_range(0, 1) ? MaxElapsed : 0;
      endcase
      if (value < 0) value = 0;
      if (value > MaxElapsed) value = MaxElapsed;
      return rssi_pkg::TimeW'(value);
   endfunction

   // One register write, mirrored into the profile copy.
   task automatic write_reg(input logic [rssi_pkg::CsrIndexW-1:0] idx,
                            input logic [rssi_pkg::WordW-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         rssi_pkg::RegStageCount: cfg_count = value[rssi_pkg::CountW-1:0];
         rssi_pkg::RegStage0, rssi_pkg::RegStage1, rssi_pkg::RegStage2,
         rssi_pkg::RegStage3: cfg_word[idx - rssi_pkg::RegStage0] = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Wait until every item is sent and every setpoint has come back.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_elapsed.size() != 0 || req_tvalid || expected_setpoints.size() != 0);
   endtask

   // New random profile, with extreme targets and durations favored.
   task automatic load_random_profile();
      logic [rssi_pkg::WordW-1:0] value;
      logic [rssi_pkg::TempW-1:0] tgt;
      logic [rssi_pkg::DurW-1:0]  dur;
      value = rssi_pkg::WordW'($urandom);
      value[rssi_pkg::CountW-1:0] = rssi_pkg::CountW'($urandom_range(0, 7));
      write_reg(rssi_pkg::RegStageCount, value);
      for (int s = 0; s < rssi_pkg::StageSlots; s++) begin
         case ($urandom_range(0, 3))
            0: tgt = '0;
            1: tgt = '1;
            default: tgt = rssi_pkg::TempW'($urandom);
         endcase
         case ($urandom_range(0, 5))
            0: dur = '0;
            1: dur = '1;
            2, 3: dur = rssi_pkg::DurW'($urandom_range(1, 40));
            default: dur = rssi_pkg::DurW'($urandom);
         endcase
         write_reg(rssi_pkg::CsrIndexW'(rssi_pkg::RegStage0 + s), {tgt, dur});
      end
      // Writes past the last register must leave the profile alone.
      if ($urandom_range(0, 3) == 0)
         write_reg(rssi_pkg::CsrIndexW'(rssi_pkg::RegStage3 + $urandom_range(1, 3)),
                   rssi_pkg::WordW'($urandom));
   endtask

   // Sender: offers pending items, with random bursts of idle cycles.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left != 0) begin
            req_tvalid <= 1'b0;
            gap_left   <= gap_left - 1;
         end else if (pending_elapsed.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= rssi_pkg::ReqDataW'(pending_elapsed.pop_front());
            if (idle_on && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 16);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (hold_seen != hold_token) begin
         hold_seen  <= hold_token;
         stall_left <= LongHold;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predicts on each input transfer, checks each result transfer.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_setpoints.size() == 0) begin
               $error("setpoint: expected none, actual %0d", rsp_tdata[rssi_pkg::TempW-1:0]);
               mismatches++;
            end else begin
               want_setpoint = expected_setpoints.pop_front();
               if (rsp_tdata[rssi_pkg::TempW-1:0] !== want_setpoint) begin
                  $error("setpoint: expected %0d, actual %0d", want_setpoint,
                         rsp_tdata[rssi_pkg::TempW-1:0]);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_setpoints.push_back(setpoint_for(req_tdata[rssi_pkg::TimeW-1:0]));
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // Watchdog: too long without any transfer.
   initial begin
      while (idle_cycles < WatchdogLimit) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   // Test sequence.
   initial begin
      for (int s = 0; s < rssi_pkg::StageSlots; s++) cfg_word[s] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      idle_on = 1'b1;

      // No stages after reset: ambient everywhere.
      pending_elapsed.push_back('0);
      pending_elapsed.push_back(rssi_pkg::TimeW'(MaxElapsed));
      wait_drained();

      // Oversized count saturates; ramp up, zero-length stage, long ramp, ramp down.
      write_reg(rssi_pkg::RegStageCount, rssi_pkg::WordW'(7));
      write_reg(rssi_pkg::RegStage0, {rssi_pkg::TempW'(8191), rssi_pkg::DurW'(100)});
      write_reg(rssi_pkg::RegStage1, {rssi_pkg::TempW'(0), rssi_pkg::DurW'(0)});
      write_reg(rssi_pkg::RegStage2, {rssi_pkg::TempW'(1000), rssi_pkg::DurW'(65535)});
      write_reg(rssi_pkg::RegStage3, {rssi_pkg::TempW'(0), rssi_pkg::DurW'(1)});
      write_reg(rssi_pkg::CsrIndexW'(rssi_pkg::RegStage3 + 1), '1);
      pending_elapsed.push_back(rssi_pkg::TimeW'(0));
      pending_elapsed.push_back(rssi_pkg::TimeW'(50));
      pending_elapsed.push_back(rssi_pkg::TimeW'(100));
      pending_elapsed.push_back(rssi_pkg::TimeW'(101));
      pending_elapsed.push_back(rssi_pkg::TimeW'(102));
      pending_elapsed.push_back(rssi_pkg::TimeW'(65635));
      pending_elapsed.push_back(rssi_pkg::TimeW'(65636));
      pending_elapsed.push_back(rssi_pkg::TimeW'(65637));
      pending_elapsed.push_back(rssi_pkg::TimeW'(MaxElapsed));
      wait_drained();

      // Single stage ramping down from ambient over the longest duration.
      write_reg(rssi_pkg::RegStageCount, rssi_pkg::WordW'(1));
      write_reg(rssi_pkg::RegStage0, {rssi_pkg::TempW'(0), rssi_pkg::DurW'(65535)});
      pending_elapsed.push_back(rssi_pkg::TimeW'(0));
      pending_elapsed.push_back(rssi_pkg::TimeW'(1));
      pending_elapsed.push_back(rssi_pkg::TimeW'(32767));
      pending_elapsed.push_back(rssi_pkg::TimeW'(65535));
      pending_elapsed.push_back(rssi_pkg::TimeW'(65536));
      wait_drained();

      // Random profiles; the sender pauses for a full drain between them.
      for (int ph = 0; ph < RandPhases; ph++) begin
         idle_on = (ph < RandPhases - 2);
         load_random_profile();
         if (ph == PressurePhase) hold_token++;
         for (int k = 0; k < PhaseItems; k++) pending_elapsed.push_back(pick_elapsed());
         wait_drained();
      end

      repeat (SettleCycles) @(posedge clock);
      if (expected_setpoints.size() != 0) begin
         $error("setpoint: %0d expected results never arrived", expected_setpoints.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
